// ----- design/olm_pkg.sv -----
// Shared types and constants for the ordered list move-by-offset block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package olm_pkg;

    // List geometry
    localparam int MAX_LEN = 1024;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = 11;
    localparam int ID_W    = 11;
    localparam int OFF_W   = 12;
    localparam int SLOT_W  = 10;

    // Target slot arithmetic: slot + signed offset, with headroom
    localparam int SUM_W   = (((ADDR_W + 2) > OFF_W) ? (ADDR_W + 2) : OFF_W) + 1;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam logic [LEN_W-1:0] LEN_RESET =
        (MAX_LEN < 1024) ? LEN_W'(MAX_LEN) : LEN_W'(1024);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_LEN);
    localparam logic REG_QLEN = 1'b0;

    // Request kinds
    localparam logic REQ_MOVE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Input word
    typedef struct packed {
        logic                     req_type;
        logic [ID_W-1:0]          item_id;
        logic signed [OFF_W-1:0]  shift_amount;
        logic [SLOT_W-1:0]        slot_index;
    } item_t;

    // Result word
    typedef struct packed {
        logic [ID_W-1:0] read_id;
        logic            found;
    } result_t;

    // Sequencer to store access
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ID_W-1:0]   wr_data;
    } store_req_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CALC,
        ST_PLAN,
        ST_SHIFT,
        ST_FINISH,
        ST_RDWAIT
    } olm_state_t;

endpackage

// ----- design/olm_store.sv -----
// List storage: single-port-write, registered-read RAM plus a fill mark.
// Slots at or above the mark read as slot+1 (the in-order list). Uses olm_pkg.
`timescale 1ns / 1ps

module olm_store
    import olm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  store_req_t      sreq,
    output logic [ID_W-1:0] rd_data
);

    logic [ID_W-1:0]   mem [MAX_LEN];
    logic [ID_W-1:0]   raw_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              fill_reg;
    logic [ADDR_W:0]   mark_reg;
    logic [ADDR_W:0]   mark_next;
    logic [ADDR_W:0]   wr_top;

    // Memory array
    always_ff @(posedge clk)
    begin
        if (sreq.wr_en)
        begin
            mem[sreq.wr_addr] <= sreq.wr_data;
        end
        if (sreq.rd_en)
        begin
            raw_reg     <= mem[sreq.rd_addr];
            rd_addr_reg <= sreq.rd_addr;
            fill_reg    <= ({1'b0, sreq.rd_addr} >= mark_reg);
        end
    end

    // Fill mark: writes are contiguous from slot 0, so it only grows until a clear resets it
    assign wr_top = {1'b0, sreq.wr_addr} + (ADDR_W+1)'(1);

    always_comb
    begin
        mark_next = mark_reg;
        if (clear)
        begin
            mark_next = '0;
        end
        else if (sreq.wr_en && (wr_top > mark_reg))
        begin
            mark_next = wr_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg <= '0;
        end
        else
        begin
            mark_reg <= mark_next;
        end
    end

    // Untouched slots read as their in-order identifier
    assign rd_data = fill_reg ? (ID_W'(rd_addr_reg) + ID_W'(1)) : raw_reg;

endmodule

// ----- design/olm_ctrl.sv -----
// Sequencer: linear search, target computation and one-slot-per-cycle shift, plus slot reads.
// Drives olm_store through a store_req_t word. Uses olm_pkg.
`timescale 1ns / 1ps

module olm_ctrl
    import olm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start_acc,
    input  item_t            item,
    input  logic [LEN_W-1:0] qlen,
    input  logic [ID_W-1:0]  rd_data,
    output store_req_t       sreq,
    output logic             busy,
    output logic             done,
    output result_t          result
);

    olm_state_t state_reg, state_next;

    logic [LEN_W-1:0]        ptr_reg, ptr_next;
    logic [LEN_W-1:0]        cnt_reg, cnt_next;
    logic [ADDR_W-1:0]       pa_reg, pa_next;
    logic                    pv_reg, pv_next;
    logic [ADDR_W-1:0]       s_reg, s_next;
    logic [ADDR_W-1:0]       t_reg, t_next;
    logic                    up_reg, up_next;
    logic [ID_W-1:0]         id_reg, id_next;
    logic signed [OFF_W-1:0] off_reg, off_next;
    logic                    hit_reg, hit_next;
    logic                    done_reg, done_next;
    result_t                 result_reg, result_next;

    logic                    issue;
    logic                    match;
    logic                    search_end;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] last;

    // Search status
    assign issue      = (ptr_reg < qlen);
    assign match      = pv_reg && (rd_data == id_reg);
    assign search_end = !pv_reg && !issue;

    // Target arithmetic: slot + offset, and last slot for clamping
    assign sum  = $signed({{(SUM_W-ADDR_W){1'b0}}, s_reg})
                + $signed({{(SUM_W-OFF_W){off_reg[OFF_W-1]}}, off_reg});
    assign last = $signed({{(SUM_W-LEN_W){1'b0}}, qlen}) - SUM_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_acc)
                begin
                    state_next = (item.req_type == REQ_READ) ? ST_RDWAIT : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    state_next = ST_CALC;
                end
                else if (search_end)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CALC:   state_next = ST_PLAN;
            ST_PLAN:   state_next = (t_reg == s_reg) ? ST_FINISH : ST_SHIFT;
            ST_SHIFT:
            begin
                if (!pv_reg && (cnt_reg == '0))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            ST_RDWAIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs: store access and result word
    always_comb
    begin
        sreq        = '0;
        done_next   = 1'b0;
        result_next = '0;
        case (state_reg)
            ST_IDLE:
            begin
                sreq.rd_en   = start_acc && (item.req_type == REQ_READ);
                sreq.rd_addr = ADDR_W'(item.slot_index);
            end
            ST_SEARCH:
            begin
                // read ahead, write back the word just seen so it leaves fill
                sreq.rd_en   = issue;
                sreq.rd_addr = ptr_reg[ADDR_W-1:0];
                sreq.wr_en   = pv_reg;
                sreq.wr_addr = pa_reg;
                sreq.wr_data = rd_data;
                if (!match && search_end)
                begin
                    done_next = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                sreq.rd_en   = (cnt_reg != '0);
                sreq.rd_addr = ptr_reg[ADDR_W-1:0];
                sreq.wr_en   = pv_reg;
                sreq.wr_addr = up_reg ? (pa_reg + ADDR_W'(1)) : (pa_reg - ADDR_W'(1));
                sreq.wr_data = rd_data;
            end
            ST_FINISH:
            begin
                sreq.wr_en        = 1'b1;
                sreq.wr_addr      = t_reg;
                sreq.wr_data      = id_reg;
                done_next         = 1'b1;
                result_next.found = 1'b1;
            end
            ST_RDWAIT:
            begin
                done_next           = 1'b1;
                result_next.found   = hit_reg;
                result_next.read_id = hit_reg ? rd_data : '0;
            end
            default:
            begin
                sreq = '0;
            end
        endcase
    end

    // Datapath registers
    always_comb
    begin
        ptr_next = ptr_reg;
        cnt_next = cnt_reg;
        pa_next  = pa_reg;
        pv_next  = pv_reg;
        s_next   = s_reg;
        t_next   = t_reg;
        up_next  = up_reg;
        id_next  = id_reg;
        off_next = off_reg;
        hit_next = hit_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_acc)
                begin
                    id_next  = item.item_id;
                    off_next = item.shift_amount;
                    hit_next = (LEN_W'(item.slot_index) < qlen);
                    ptr_next = '0;
                    pv_next  = 1'b0;
                end
            end
            ST_SEARCH:
            begin
                if (issue)
                begin
                    pa_next  = ptr_reg[ADDR_W-1:0];
                    ptr_next = ptr_reg + LEN_W'(1);
                    pv_next  = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
                if (match)
                begin
                    s_next = pa_reg;
                end
            end
            ST_CALC:
            begin
                // clamp target to [0, qlen-1]
                if (sum < 0)
                begin
                    t_next = '0;
                end
                else if (sum > last)
                begin
                    t_next = last[ADDR_W-1:0];
                end
                else
                begin
                    t_next = sum[ADDR_W-1:0];
                end
            end
            ST_PLAN:
            begin
                up_next = (t_reg < s_reg);
                pv_next = 1'b0;
                if (t_reg < s_reg)
                begin
                    cnt_next = LEN_W'(s_reg - t_reg);
                    ptr_next = LEN_W'(s_reg) - LEN_W'(1);
                end
                else
                begin
                    cnt_next = LEN_W'(t_reg - s_reg);
                    ptr_next = LEN_W'(s_reg) + LEN_W'(1);
                end
            end
            ST_SHIFT:
            begin
                if (cnt_reg != '0)
                begin
                    pa_next  = ptr_reg[ADDR_W-1:0];
                    ptr_next = up_reg ? (ptr_reg - LEN_W'(1)) : (ptr_reg + LEN_W'(1));
                    cnt_next = cnt_reg - LEN_W'(1);
                    pv_next  = 1'b1;
                end
                else
                begin
                    pv_next = 1'b0;
                end
            end
            default:
            begin
                pv_next = pv_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pv_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        pa_reg     <= pa_next;
        s_reg      <= s_next;
        t_reg      <= t_next;
        up_reg     <= up_next;
        id_reg     <= id_next;
        off_reg    <= off_next;
        hit_reg    <= hit_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Results never come in adjacent cycles
    a_done_gap: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("olm_ctrl: results in adjacent cycles");

    // Writes stay inside the list in use
    a_wr_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        sreq.wr_en |-> (LEN_W'(sreq.wr_addr) < qlen))
        else $error("olm_ctrl: write beyond list length");

    // No store writes while idle
    a_idle_no_wr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !sreq.wr_en)
        else $error("olm_ctrl: write while idle");

    // A miss never carries an identifier
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !result_reg.found) |-> (result_reg.read_id == '0))
        else $error("olm_ctrl: miss with nonzero identifier");

endmodule

// ----- design/ordered_list_move_by_offset_core.sv -----
// Top level: APB register for the list length, sequencer and list storage.
// Depends on olm_pkg, olm_store and olm_ctrl.
// A read passes the read-wait state to done. A move searches from slot 0 to the found
// slot s, clamps target t, shifts the slots between (none if t = s), writes the item at
// t; a miss scans the list. One word at a time: the next is taken as done leaves.
// Reset and length writes restore the in-order list at once through a fill mark.
`timescale 1ns / 1ps

module ordered_list_move_by_offset_core
    import olm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // command channel
    input  logic               start,
    input  item_t              item,
    output logic               busy,
    // result channel
    output logic               done,
    output result_t            result,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [LEN_W-1:0] qlen_reg, qlen_next;
    logic             cfg_wr;
    logic             start_acc;
    store_req_t       sreq;
    logic [ID_W-1:0]  rd_data;

    assign pready    = 1'b1;
    assign start_acc = start && !busy;

    // Length register: saturate to the list depth; a write restarts the list
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_QLEN);

    always_comb
    begin
        qlen_next = qlen_reg;
        if (cfg_wr)
        begin
            qlen_next = (pwdata[LEN_W-1:0] > LEN_MAX) ? LEN_MAX : pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg <= LEN_RESET;
        end
        else
        begin
            qlen_reg <= qlen_next;
        end
    end

    assign prdata = (paddr[2] == REG_QLEN) ? {{(32-LEN_W){1'b0}}, qlen_reg} : '0;

    olm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start_acc (start_acc),
        .item      (item),
        .qlen      (qlen_reg),
        .rd_data   (rd_data),
        .sreq      (sreq),
        .busy      (busy),
        .done      (done),
        .result    (result)
    );

    olm_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (cfg_wr),
        .sreq    (sreq),
        .rd_data (rd_data)
    );

endmodule
